// ===== rtl/lpd_pkg.sv =====
// Shared types and constants for the addressable LED pixel driver.
`default_nettype none

package lpd_pkg;

    localparam int DEF_MAX_PIXELS = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PIXELS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_SLOT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_SLOT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_SLOT  = 3'd7;

    localparam logic [8:0]  RST_NUM_PIXELS = 9'd64;
    localparam logic [7:0]  RST_ZERO_HIGH  = 8'd5;
    localparam logic [7:0]  RST_ONE_HIGH   = 8'd13;
    localparam logic [7:0]  RST_BIT_TICKS  = 8'd20;
    localparam logic [15:0] RST_LATCH      = 16'd960;
    localparam logic [1:0]  RST_RED_SLOT   = 2'd1;
    localparam logic [1:0]  RST_GREEN_SLOT = 2'd0;
    localparam logic [1:0]  RST_BLUE_SLOT  = 2'd2;

    // Bytes per pixel and bits per pixel row
    localparam int ROW_BYTES = 3;
    localparam int ROW_W     = 8 * ROW_BYTES;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_SHOW  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SEND  = 2'd1,
        PH_LATCH = 2'd2
    } t_phase;

    typedef struct packed {
        logic [8:0]  num_pixels;
        logic [7:0]  zero_high;
        logic [7:0]  one_high;
        logic [7:0]  bit_ticks;
        logic [15:0] latch_ticks;
        logic [1:0]  red_slot;
        logic [1:0]  green_slot;
        logic [1:0]  blue_slot;
    } t_cfg;

    // Store request: byte write (zero-filled outside the chosen slots) or full clear
    typedef struct packed {
        logic                 wr;
        logic                 clr;
        logic [ROW_BYTES-1:0] be;
        logic [ROW_W-1:0]     data;
    } t_store_req;

endpackage

`default_nettype wire

// ===== rtl/lpd_ifs.sv =====
// Valid/ready channel interfaces for items in and results out.
`default_nettype none

interface lpd_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, op, pixel_index, red, green, blue, input ready);
    modport sink   (input valid, op, pixel_index, red, green, blue, output ready);
endinterface

interface lpd_res_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;

    modport source (output valid, line_level, busy_res, input ready);
    modport sink   (input valid, line_level, busy_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/lpd_store.sv =====
// Pixel store: one 24-bit row per pixel, per-row valid bits, row 0 mirror.
`default_nettype none

module lpd_store #(
    parameter int MAX_PIXELS = lpd_pkg::DEF_MAX_PIXELS,
    parameter int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire lpd_pkg::t_store_req       i_req,
    input  wire logic [AW-1:0]             i_wr_addr,
    input  wire logic [AW-1:0]             i_rd_addr,
    output logic [lpd_pkg::ROW_W-1:0]      o_rd_row,
    output logic                           o_rd_vld,
    output logic [lpd_pkg::ROW_W-1:0]      o_row0
);
    import lpd_pkg::*;

    logic [ROW_W-1:0]      mem [MAX_PIXELS];
    logic [MAX_PIXELS-1:0] r_valid;
    logic [ROW_W-1:0]      r_rd_row;
    logic                  r_rd_vld;
    logic [ROW_W-1:0]      r_row0;
    logic [ROW_BYTES-1:0]  eff_be;

    // A row never written since the last clear takes every byte, zeros included
    assign eff_be = r_valid[i_wr_addr] ? i_req.be : {ROW_BYTES{1'b1}};

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            for (int s = 0; s < ROW_BYTES; s++) begin
                if (eff_be[s]) begin
                    mem[i_wr_addr][8*s +: 8] <= i_req.data[8*s +: 8];
                end
            end
        end
        r_rd_row <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
            r_row0   <= '0;
        end else begin
            r_rd_vld <= r_valid[i_rd_addr];
            if (i_req.clr) begin
                r_valid <= '0;
                r_row0  <= '0;
            end else if (i_req.wr) begin
                r_valid[i_wr_addr] <= 1'b1;
                if (i_wr_addr == '0) begin
                    for (int s = 0; s < ROW_BYTES; s++) begin
                        if (eff_be[s]) begin
                            r_row0[8*s +: 8] <= i_req.data[8*s +: 8];
                        end
                    end
                end
            end
        end
    end

    assign o_rd_row = r_rd_row;
    assign o_rd_vld = r_rd_vld;
    assign o_row0   = r_row0;

endmodule

`default_nettype wire

// ===== rtl/lpd_engine.sv =====
// Serial engine: show sequencing, bit timing, latch hold and store requests.
`default_nettype none

module lpd_engine #(
    parameter int MAX_PIXELS = lpd_pkg::DEF_MAX_PIXELS,
    parameter int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_step,
    input  wire logic [1:0]                i_op,
    input  wire logic [7:0]                i_pixel_index,
    input  wire logic [7:0]                i_red,
    input  wire logic [7:0]                i_green,
    input  wire logic [7:0]                i_blue,
    input  wire lpd_pkg::t_cfg             i_cfg,
    input  wire logic [lpd_pkg::ROW_W-1:0] i_rd_row,
    input  wire logic                      i_rd_vld,
    input  wire logic [lpd_pkg::ROW_W-1:0] i_row0,
    output lpd_pkg::t_store_req            o_req,
    output logic [AW-1:0]                  o_wr_addr,
    output logic [AW-1:0]                  o_rd_addr,
    output logic                           o_line_level,
    output logic                           o_busy
);
    import lpd_pkg::*;

    localparam int CW = $clog2(MAX_PIXELS + 1);

    t_phase           r_phase, n_phase;
    logic [7:0]       r_tick, n_tick;
    logic [2:0]       r_bit, n_bit;
    logic [1:0]       r_slot, n_slot;
    logic [AW-1:0]    r_pix, n_pix;
    logic [ROW_W-1:0] r_row, n_row;
    logic [7:0]       r_shift, n_shift;
    logic [15:0]      r_latch, n_latch;

    t_op              op;
    logic [CW-1:0]    n_eff;
    logic             bit_end;
    logic             last_byte;
    logic             idle;
    logic [ROW_W-1:0] next_row;
    logic [ROW_W-1:0] set_data;
    logic [2:0]       set_be;
    logic [15:0]      latch_dec;
    logic [7:0]       high_ticks;
    logic [31:0]      idx_w;

    assign op   = t_op'(i_op);
    assign idle = (r_phase == PH_IDLE);

    always_comb begin
        if (32'(i_cfg.num_pixels) > 32'(MAX_PIXELS)) begin
            n_eff = CW'(MAX_PIXELS);
        end else begin
            n_eff = CW'(i_cfg.num_pixels);
        end
    end

    assign bit_end   = ({1'b0, r_tick} + 9'd1) >= {1'b0, i_cfg.bit_ticks};
    assign last_byte = (r_slot == 2'd2) && ((32'(r_pix) + 32'd1) == 32'(n_eff));
    assign next_row  = i_rd_vld ? i_rd_row : '0;
    assign latch_dec = r_latch - 16'd1;
    assign idx_w     = 32'(i_pixel_index);

    // Later colors win a shared slot; slot three writes nothing
    always_comb begin
        for (int s = 0; s < ROW_BYTES; s++) begin
            set_be[s] = (32'(i_cfg.red_slot) == s) || (32'(i_cfg.green_slot) == s)
                     || (32'(i_cfg.blue_slot) == s);
            if (32'(i_cfg.blue_slot) == s) begin
                set_data[8*s +: 8] = i_blue;
            end else if (32'(i_cfg.green_slot) == s) begin
                set_data[8*s +: 8] = i_green;
            end else if (32'(i_cfg.red_slot) == s) begin
                set_data[8*s +: 8] = i_red;
            end else begin
                set_data[8*s +: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        o_req.wr   = i_step && idle && (op == OP_SET) && (idx_w < 32'(n_eff));
        o_req.clr  = i_step && idle && (op == OP_CLEAR);
        o_req.be   = set_be;
        o_req.data = set_data;
    end

    assign o_wr_addr = idx_w[AW-1:0];
    // Prefetch the following pixel while the current one goes out
    assign o_rd_addr = r_pix + AW'(1);

    // Next state and datapath
    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_slot  = r_slot;
        n_pix   = r_pix;
        n_row   = r_row;
        n_shift = r_shift;
        n_latch = r_latch;
        if (op == OP_TICK) begin
            unique case (r_phase)
                PH_SEND: begin
                    if (bit_end) begin
                        n_tick = 8'd0;
                        if (r_bit == 3'd7) begin
                            n_bit = 3'd0;
                            if (last_byte) begin
                                n_shift = 8'd0;
                                if (i_cfg.latch_ticks == 16'd0) begin
                                    n_phase = PH_IDLE;
                                    n_latch = 16'd0;
                                end else begin
                                    n_phase = PH_LATCH;
                                    n_latch = i_cfg.latch_ticks;
                                end
                            end else if (r_slot == 2'd2) begin
                                n_pix   = r_pix + AW'(1);
                                n_slot  = 2'd0;
                                n_row   = next_row;
                                n_shift = next_row[7:0];
                            end else begin
                                n_slot  = r_slot + 2'd1;
                                n_shift = r_row[8*(r_slot + 2'd1) +: 8];
                            end
                        end else begin
                            n_bit   = r_bit + 3'd1;
                            n_shift = {r_shift[6:0], 1'b0};
                        end
                    end else begin
                        n_tick = r_tick + 8'd1;
                    end
                end
                PH_LATCH: begin
                    n_latch = latch_dec;
                    if (latch_dec == 16'd0) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_IDLE: begin
                end
                default: begin
                end
            endcase
        end else if (idle && (op == OP_SHOW)) begin
            n_tick = 8'd0;
            n_pix  = '0;
            n_slot = 2'd0;
            n_bit  = 3'd0;
            if (n_eff == '0) begin
                n_shift = 8'd0;
                if (i_cfg.latch_ticks == 16'd0) begin
                    n_phase = PH_IDLE;
                    n_latch = 16'd0;
                end else begin
                    n_phase = PH_LATCH;
                    n_latch = i_cfg.latch_ticks;
                end
            end else begin
                n_row   = i_row0;
                n_shift = i_row0[7:0];
                n_phase = PH_SEND;
            end
        end
    end

    // Outputs: line level and busy after this item
    always_comb begin
        high_ticks   = n_shift[7] ? i_cfg.one_high : i_cfg.zero_high;
        o_line_level = (n_phase == PH_SEND) && (n_tick < high_ticks);
        o_busy       = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= 8'd0;
            r_bit   <= 3'd0;
            r_slot  <= 2'd0;
            r_pix   <= '0;
            r_shift <= 8'd0;
            r_latch <= 16'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_slot  <= n_slot;
            r_pix   <= n_pix;
            r_shift <= n_shift;
            r_latch <= n_latch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/addressable_led_pixel_driver_top.sv =====
// Addressable LED pixel driver: top level with channel registers and configuration.
//
// Items arrive on item_in (op, pixel_index, red, green, blue) and each one gives
// exactly one result on res_out (line_level, busy_res). op tick advances the
// serial waveform by one time unit; set writes a pixel, clear zeroes the store,
// show starts sending. set, clear and show are ignored while busy.
// An item passes through the input register, then the engine step into the result
// register. Throughput is one item per cycle while res_out is not stalled; the
// engine steps once per item and prefetches the next pixel row from the
// store's read port.
// When res_out is stalled the result register holds, the input register fills,
// and item_in.ready drops only once both are occupied.
// Reset (i_rst_n low, synchronous) restores the default configuration, empties
// both registers, returns the engine to idle and marks every pixel row as zero;
// no clearing pass is needed. The configuration port writes register i_cfg_idx
// on any clock with i_cfg_we high; write it only while the block is idle.
`default_nettype none

module addressable_led_pixel_driver_top #(
    parameter int MAX_PIXELS = lpd_pkg::DEF_MAX_PIXELS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lpd_item_if.sink                            item_in,
    lpd_res_if.source                           res_out
);
    import lpd_pkg::*;

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    t_cfg        r_cfg;
    logic        r_in_vld;
    logic [1:0]  r_op;
    logic [7:0]  r_idx;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;
    logic        r_out_vld;
    logic        r_line;
    logic        r_busy;

    logic             step;
    logic             in_xfer;
    t_store_req       req;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [ROW_W-1:0] rd_row;
    logic             rd_vld;
    logic [ROW_W-1:0] row0;
    logic             line_nx;
    logic             busy_nx;

    assign step          = r_in_vld && (!r_out_vld || res_out.ready);
    assign item_in.ready = !r_in_vld || step;
    assign in_xfer       = item_in.valid && item_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_pixels  <= RST_NUM_PIXELS;
            r_cfg.zero_high   <= RST_ZERO_HIGH;
            r_cfg.one_high    <= RST_ONE_HIGH;
            r_cfg.bit_ticks   <= RST_BIT_TICKS;
            r_cfg.latch_ticks <= RST_LATCH;
            r_cfg.red_slot    <= RST_RED_SLOT;
            r_cfg.green_slot  <= RST_GREEN_SLOT;
            r_cfg.blue_slot   <= RST_BLUE_SLOT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUM_PIXELS: r_cfg.num_pixels  <= i_cfg_data[8:0];
                CFG_ZERO_HIGH:  r_cfg.zero_high   <= i_cfg_data[7:0];
                CFG_ONE_HIGH:   r_cfg.one_high    <= i_cfg_data[7:0];
                CFG_BIT_TICKS:  r_cfg.bit_ticks   <= i_cfg_data[7:0];
                CFG_LATCH:      r_cfg.latch_ticks <= i_cfg_data[15:0];
                CFG_RED_SLOT:   r_cfg.red_slot    <= i_cfg_data[1:0];
                CFG_GREEN_SLOT: r_cfg.green_slot  <= i_cfg_data[1:0];
                CFG_BLUE_SLOT:  r_cfg.blue_slot   <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: load on transfer, drop once the engine consumes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op    <= item_in.op;
            r_idx   <= item_in.pixel_index;
            r_red   <= item_in.red;
            r_green <= item_in.green;
            r_blue  <= item_in.blue;
        end
    end

    // Result register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (res_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_line <= line_nx;
            r_busy <= busy_nx;
        end
    end

    assign res_out.valid      = r_out_vld;
    assign res_out.line_level = r_line;
    assign res_out.busy_res   = r_busy;

    lpd_engine #(
        .MAX_PIXELS (MAX_PIXELS),
        .AW         (AW)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_op          (r_op),
        .i_pixel_index (r_idx),
        .i_red         (r_red),
        .i_green       (r_green),
        .i_blue        (r_blue),
        .i_cfg         (r_cfg),
        .i_rd_row      (rd_row),
        .i_rd_vld      (rd_vld),
        .i_row0        (row0),
        .o_req         (req),
        .o_wr_addr     (wr_addr),
        .o_rd_addr     (rd_addr),
        .o_line_level  (line_nx),
        .o_busy        (busy_nx)
    );

    lpd_store #(
        .MAX_PIXELS (MAX_PIXELS),
        .AW         (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .i_wr_addr (wr_addr),
        .i_rd_addr (rd_addr),
        .o_rd_row  (rd_row),
        .o_rd_vld  (rd_vld),
        .o_row0    (row0)
    );

endmodule

`default_nettype wire

// ===== rtl/lpd_checker.sv =====
// Port-level checker for the pixel driver, bound to the top level.
`default_nettype none

module lpd_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_ready,
    input  wire logic i_res_valid,
    input  wire logic i_res_ready,
    input  wire logic i_res_line,
    input  wire logic i_res_busy
);

    // Stalled result holds its value
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_line) && $stable(i_res_busy))
        else $error("result changed while stalled");

    // Line can only be high while a show is running
    a_line_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_line |-> i_res_busy)
        else $error("line high while not busy");

    // With an empty result register the input side never stalls
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid |-> i_in_ready)
        else $error("input stalled with result register empty");

    // Reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

endmodule

bind addressable_led_pixel_driver_top lpd_checker u_lpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (item_in.ready),
    .i_res_valid (res_out.valid),
    .i_res_ready (res_out.ready),
    .i_res_line  (res_out.line_level),
    .i_res_busy  (res_out.busy_res)
);

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the addressable LED pixel driver: predicts line level and busy for every item.
module testbench;
    import lpd_pkg::*;

    localparam int STORE_BYTES  = ROW_BYTES * DEF_MAX_PIXELS;
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int RANDOM_ITEMS = 750;

    typedef struct packed {
        logic line;
        logic busy;
    } t_line_sample;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lpd_item_if item_in ();
    lpd_res_if  res_out ();

    addressable_led_pixel_driver_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .item_in    (item_in),
        .res_out    (res_out)
    );

    // Predicted configuration
    logic [8:0]  cfg_pixels;
    logic [7:0]  cfg_zero_high;
    logic [7:0]  cfg_one_high;
    logic [7:0]  cfg_bit_ticks;
    logic [15:0] cfg_latch;
    logic [1:0]  cfg_red_slot;
    logic [1:0]  cfg_green_slot;
    logic [1:0]  cfg_blue_slot;

    // Predicted engine state
    logic [7:0]  strip [STORE_BYTES];
    int unsigned byte_ptr;
    logic [7:0]  shifter;
    logic [3:0]  bits_to_go;
    logic [7:0]  bit_tick;
    logic [15:0] latch_left;
    t_phase      drv_phase;

    t_line_sample line_due [$];
    int           errors;
    int           results_seen;
    int unsigned  cycles;
    logic         steady;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_error(string msg);
        $display("%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic int unsigned pixels_used();
        return (cfg_pixels > DEF_MAX_PIXELS) ? DEF_MAX_PIXELS : cfg_pixels;
    endfunction

    function automatic void clear_strip();
        foreach (strip[i]) strip[i] = 8'h00;
    endfunction

    function automatic void start_latch();
        if (cfg_latch == 16'd0) begin
            drv_phase  = PH_IDLE;
            latch_left = 16'd0;
        end else begin
            drv_phase  = PH_LATCH;
            latch_left = cfg_latch;
        end
    endfunction

    function automatic void put_color(int unsigned base, logic [1:0] slot, logic [7:0] value);
        if (slot < 2'd3) strip[base + slot] = value;
    endfunction

    // Apply one accepted item to the predicted engine and queue the line sample it yields
    function automatic void line_step(t_op op, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                      logic [7:0] b);
        t_line_sample s;
        logic [7:0]   high_ticks;
        int unsigned  base;
        if (op == OP_TICK) begin
            if (drv_phase == PH_SEND) begin
                if (int'(bit_tick) + 1 >= int'(cfg_bit_ticks)) begin
                    bit_tick   = 8'd0;
                    bits_to_go = bits_to_go - 4'd1;
                    if (bits_to_go == 4'd0) begin
                        byte_ptr++;
                        if (byte_ptr >= ROW_BYTES * pixels_used()) begin
                            shifter = 8'h00;
                            start_latch();
                        end else begin
                            shifter    = strip[byte_ptr];
                            bits_to_go = 4'd8;
                        end
                    end else begin
                        shifter = shifter << 1;
                    end
                end else begin
                    bit_tick++;
                end
            end else if (drv_phase == PH_LATCH) begin
                latch_left--;
                if (latch_left == 16'd0) drv_phase = PH_IDLE;
            end
        end else if (drv_phase == PH_IDLE) begin
            case (op)
                OP_SET: begin
                    if (idx < pixels_used()) begin
                        base = int'(idx) * ROW_BYTES;
                        // later colors win a shared slot
                        put_color(base, cfg_red_slot, r);
                        put_color(base, cfg_green_slot, g);
                        put_color(base, cfg_blue_slot, b);
                    end
                end
                OP_CLEAR: clear_strip();
                OP_SHOW: begin
                    byte_ptr = 0;
                    bit_tick = 8'd0;
                    if (pixels_used() == 0) begin
                        shifter    = 8'h00;
                        bits_to_go = 4'd0;
                        start_latch();
                    end else begin
                        shifter    = strip[0];
                        bits_to_go = 4'd8;
                        drv_phase  = PH_SEND;
                    end
                end
                default: ;
            endcase
        end
        high_ticks = shifter[7] ? cfg_one_high : cfg_zero_high;
        s.line = (drv_phase == PH_SEND) && (bit_tick < high_ticks);
        s.busy = (drv_phase != PH_IDLE);
        line_due.push_back(s);
    endfunction

    // Drive one item and hold it until the transfer
    task automatic send_item(t_op op, logic [7:0] idx = 8'd0, logic [7:0] r = 8'd0,
                             logic [7:0] g = 8'd0, logic [7:0] b = 8'd0);
        if (!steady && $urandom_range(0, 99) < 33) begin
            item_in.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        item_in.valid       <= 1'b1;
        item_in.op          <= op;
        item_in.pixel_index <= idx;
        item_in.red         <= r;
        item_in.green       <= g;
        item_in.blue        <= b;
        do @(posedge i_clk); while (!item_in.ready);
        line_step(op, idx, r, g, b);
    endtask

    // Tick the show out, then hold off until every result is back
    task automatic settle_line();
        while (drv_phase != PH_IDLE) send_item(OP_TICK);
        item_in.valid <= 1'b0;
        while (line_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_NUM_PIXELS: cfg_pixels     = value[8:0];
            CFG_ZERO_HIGH:  cfg_zero_high  = value[7:0];
            CFG_ONE_HIGH:   cfg_one_high   = value[7:0];
            CFG_BIT_TICKS:  cfg_bit_ticks  = value[7:0];
            CFG_LATCH:      cfg_latch      = value;
            CFG_RED_SLOT:   cfg_red_slot   = value[1:0];
            CFG_GREEN_SLOT: cfg_green_slot = value[1:0];
            CFG_BLUE_SLOT:  cfg_blue_slot  = value[1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(t_cfg c);
        settle_line();
        write_reg(CFG_NUM_PIXELS, CFG_DATA_W'(c.num_pixels));
        write_reg(CFG_ZERO_HIGH,  CFG_DATA_W'(c.zero_high));
        write_reg(CFG_ONE_HIGH,   CFG_DATA_W'(c.one_high));
        write_reg(CFG_BIT_TICKS,  CFG_DATA_W'(c.bit_ticks));
        write_reg(CFG_LATCH,      c.latch_ticks);
        write_reg(CFG_RED_SLOT,   CFG_DATA_W'(c.red_slot));
        write_reg(CFG_GREEN_SLOT, CFG_DATA_W'(c.green_slot));
        write_reg(CFG_BLUE_SLOT,  CFG_DATA_W'(c.blue_slot));
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    // Reset configuration: sets at both ends of the chain, one show, ops dropped while busy
    task automatic test_defaults();
        send_item(OP_TICK);
        send_item(OP_SET, 8'd0, 8'hFF, 8'h00, 8'h80);
        send_item(OP_SET, 8'd63, 8'hAA, 8'h55, 8'hFF);
        send_item(OP_SET, 8'd64, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_SET, 8'd255, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_SHOW);
        send_item(OP_TICK);
        send_item(OP_SET, 8'd0, 8'h00, 8'h00, 8'h00);
        send_item(OP_CLEAR);
        send_item(OP_SHOW);
        settle_line();
    endtask

    // Shared slots and the unused slot value
    task automatic test_slot_mapping();
        load_config('{num_pixels: 9'd3, zero_high: 8'd1, one_high: 8'd2, bit_ticks: 8'd3,
                      latch_ticks: 16'd2, red_slot: 2'd0, green_slot: 2'd0, blue_slot: 2'd0});
        send_item(OP_CLEAR);
        send_item(OP_SET, 8'd0, 8'h11, 8'h22, 8'h33);
        load_config('{num_pixels: 9'd3, zero_high: 8'd1, one_high: 8'd2, bit_ticks: 8'd3,
                      latch_ticks: 16'd2, red_slot: 2'd3, green_slot: 2'd2, blue_slot: 2'd1});
        send_item(OP_SET, 8'd1, 8'h44, 8'h55, 8'h66);
        send_item(OP_SET, 8'd3, 8'hFF, 8'hFF, 8'hFF);
        load_config('{num_pixels: 9'd3, zero_high: 8'd1, one_high: 8'd2, bit_ticks: 8'd3,
                      latch_ticks: 16'd2, red_slot: 2'd2, green_slot: 2'd1, blue_slot: 2'd0});
        send_item(OP_SET, 8'd2, 8'h77, 8'h88, 8'h99);
        send_item(OP_SHOW);
        settle_line();
    endtask

    // Zero high time, high time past the period, short and long bit periods, zero latch
    task automatic test_bit_shapes();
        load_config('{num_pixels: 9'd1, zero_high: 8'd0, one_high: 8'd255, bit_ticks: 8'd1,
                      latch_ticks: 16'd0, red_slot: 2'd1, green_slot: 2'd0, blue_slot: 2'd2});
        send_item(OP_SET, 8'd0, 8'hA5, 8'h3C, 8'hFF);
        send_item(OP_SHOW);
        load_config('{num_pixels: 9'd1, zero_high: 8'd255, one_high: 8'd0, bit_ticks: 8'd0,
                      latch_ticks: 16'd3, red_slot: 2'd1, green_slot: 2'd0, blue_slot: 2'd2});
        send_item(OP_SHOW);
        load_config('{num_pixels: 9'd1, zero_high: 8'd254, one_high: 8'd1, bit_ticks: 8'd255,
                      latch_ticks: 16'd1, red_slot: 2'd1, green_slot: 2'd0, blue_slot: 2'd2});
        send_item(OP_SHOW);
        settle_line();
        send_item(OP_CLEAR);
        send_item(OP_SHOW);
        settle_line();
    endtask

    // Empty chain with the longest latch, then a chain count above the store size
    task automatic test_chain_length();
        steady = 1'b1;
        load_config('{num_pixels: 9'd0, zero_high: 8'd1, one_high: 8'd1, bit_ticks: 8'd2,
                      latch_ticks: 16'hFFFF, red_slot: 2'd1, green_slot: 2'd0, blue_slot: 2'd2});
        send_item(OP_SET, 8'd0, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_SHOW);
        load_config('{num_pixels: 9'd511, zero_high: 8'd1, one_high: 8'd1, bit_ticks: 8'd1,
                      latch_ticks: 16'd1, red_slot: 2'd1, green_slot: 2'd0, blue_slot: 2'd2});
        send_item(OP_SET, 8'd255, 8'hFF, 8'h01, 8'h80);
        send_item(OP_SET, 8'd0, 8'h7F, 8'hFE, 8'h00);
        send_item(OP_SHOW);
        settle_line();
        steady = 1'b0;
    endtask

    task automatic test_random();
        t_cfg        c;
        int unsigned done;
        int unsigned budget;
        int unsigned roll;
        int unsigned span;
        logic [7:0]  idx;
        done = 0;
        steady = 1'b1;
        while (done < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 49);
            if (roll == 0)      c.num_pixels = 9'd0;
            else if (roll == 1) c.num_pixels = 9'($urandom_range(257, 511));
            else if (roll == 2) c.num_pixels = 9'd256;
            else                c.num_pixels = 9'($urandom_range(1, 4));
            if (c.num_pixels > 9'd16) c.bit_ticks = 8'($urandom_range(0, 2));
            else                      c.bit_ticks = 8'($urandom_range(0, 12));
            c.zero_high = ($urandom_range(0, 9) == 0) ? 8'd255
                        : 8'($urandom_range(0, int'(c.bit_ticks) + 2));
            c.one_high  = ($urandom_range(0, 9) == 0) ? 8'd255
                        : 8'($urandom_range(0, int'(c.bit_ticks) + 2));
            roll = $urandom_range(0, 9);
            if (roll == 0)      c.latch_ticks = 16'd0;
            else if (roll == 1) c.latch_ticks = 16'($urandom_range(100, 400));
            else                c.latch_ticks = 16'($urandom_range(1, 20));
            c.red_slot   = 2'($urandom_range(0, 3));
            c.green_slot = 2'($urandom_range(0, 3));
            c.blue_slot  = 2'($urandom_range(0, 3));
            load_config(c);
            budget = $urandom_range(30, 70);
            while (budget != 0) begin
                roll = $urandom_range(0, 99);
                if (drv_phase != PH_IDLE) begin
                    // mostly ticks while busy, with ops that must be dropped
                    if (roll < 90) send_item(OP_TICK, rand_byte(), rand_byte(), rand_byte(),
                                             rand_byte());
                    else send_item(t_op'($urandom_range(1, 3)), rand_byte(), rand_byte(),
                                   rand_byte(), rand_byte());
                end else begin
                    budget--;
                    done++;
                    if (roll < 60) begin
                        span = pixels_used();
                        if (span != 0 && $urandom_range(0, 4) != 0)
                            idx = 8'($urandom_range(0, span - 1));
                        else
                            idx = rand_byte();
                        send_item(OP_SET, idx, rand_byte(), rand_byte(), rand_byte());
                    end else if (roll < 72) begin
                        send_item(OP_SHOW, rand_byte(), rand_byte(), rand_byte(), rand_byte());
                    end else if (roll < 78) begin
                        send_item(OP_CLEAR, rand_byte(), rand_byte(), rand_byte(), rand_byte());
                    end else begin
                        send_item(OP_TICK, rand_byte(), rand_byte(), rand_byte(), rand_byte());
                    end
                end
            end
            steady = 1'b0;
        end
        settle_line();
    endtask

    // Result side: random stalls, compare each transfer with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_line_sample want;
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
        res_out.ready <= steady || ($urandom_range(0, 99) >= 33);
        if (i_rst_n && res_out.valid && res_out.ready) begin
            results_seen++;
            if (line_due.size() == 0) begin
                flag_error($sformatf("result %0d arrived with nothing due", results_seen));
            end else begin
                want = line_due.pop_front();
                if (res_out.line_level !== want.line)
                    flag_error($sformatf("result %0d line_level %b, want %b", results_seen,
                                         res_out.line_level, want.line));
                if (res_out.busy_res !== want.busy)
                    flag_error($sformatf("result %0d busy_res %b, want %b", results_seen,
                                         res_out.busy_res, want.busy));
            end
        end
    end

    initial begin
        errors       = 0;
        results_seen = 0;
        cycles       = 0;
        steady       = 1'b0;

        cfg_pixels     = RST_NUM_PIXELS;
        cfg_zero_high  = RST_ZERO_HIGH;
        cfg_one_high   = RST_ONE_HIGH;
        cfg_bit_ticks  = RST_BIT_TICKS;
        cfg_latch      = RST_LATCH;
        cfg_red_slot   = RST_RED_SLOT;
        cfg_green_slot = RST_GREEN_SLOT;
        cfg_blue_slot  = RST_BLUE_SLOT;
        clear_strip();
        byte_ptr   = 0;
        shifter    = 8'h00;
        bits_to_go = 4'd0;
        bit_tick   = 8'd0;
        latch_left = 16'd0;
        drv_phase  = PH_IDLE;

        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= CFG_NUM_PIXELS;
        i_cfg_data          <= '0;
        item_in.valid       <= 1'b0;
        item_in.op          <= OP_TICK;
        item_in.pixel_index <= 8'd0;
        item_in.red         <= 8'd0;
        item_in.green       <= 8'd0;
        item_in.blue        <= 8'd0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults();
        test_slot_mapping();
        test_bit_shapes();
        test_chain_length();
        test_random();

        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lpd_pkg.sv
rtl/lpd_ifs.sv
rtl/lpd_store.sv
rtl/lpd_engine.sv
rtl/addressable_led_pixel_driver_top.sv
rtl/lpd_checker.sv
test/testbench.sv
